// ----- rtl/core/frame_loop_playback_controller_defines.svh -----
// assertion macros for the frame loop playback controller
// expects clk and rst_n in the scope where a macro is used
`ifndef FRAME_LOOP_PLAYBACK_CONTROLLER_DEFINES_SVH
`define FRAME_LOOP_PLAYBACK_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define FLPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/flpc_pkg.sv -----
// shared types and constants of the frame loop playback controller
// no dependencies
package flpc_pkg;

  localparam logic [2:0] CMD_RECORD = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_PLAY   = 3'd2;
  localparam logic [2:0] CMD_PAUSE  = 3'd3;
  localparam logic [2:0] CMD_RESUME = 3'd4;
  localparam logic [2:0] CMD_STOP   = 3'd5;
  localparam logic [2:0] CMD_SEEK   = 3'd6;
  localparam logic [2:0] CMD_CLEAR  = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SOON  = 3'd1;
  localparam logic [2:0] ST_PLAYING   = 3'd2;
  localparam logic [2:0] ST_OUT_ORDER = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // mode flag bit positions
  localparam int FL_PLAYING = 0;
  localparam int FL_PAUSED  = 1;
  localparam int FL_DONE    = 2;
  localparam int FL_FIRST   = 3;

  localparam logic [2:0] REG_PERIOD   = 3'd0;
  localparam logic [2:0] REG_LOOP     = 3'd1;
  localparam logic [2:0] REG_FI_EN    = 3'd2;
  localparam logic [2:0] REG_FI_TICKS = 3'd3;
  localparam logic [2:0] REG_FO_EN    = 3'd4;
  localparam logic [2:0] REG_FO_TICKS = 3'd5;
  localparam logic [2:0] REG_ALPHA    = 3'd6;

  localparam int NUM_W = 24;
  localparam int DEN_W = 16;
  localparam int QUO_W = 8;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk_step;
    logic fade_init;
    logic div_in;
    logic div_out;
  } flpc_cmd_t;

  typedef struct packed {
    logic walk;
    logic walk_more;
    logic need_in;
    logic need_out;
    logic div_done;
  } flpc_stat_t;

endpackage

// ----- rtl/core/flpc_div.sv -----
// restoring divider for the fade ratio, one quotient bit per cycle
// depends on flpc_pkg; quotient known to fit in QUO_W bits
module flpc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [flpc_pkg::NUM_W-1:0] num,
  input  logic [flpc_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [flpc_pkg::QUO_W-1:0] quot
);
  logic [flpc_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [flpc_pkg::DEN_W-1:0] den_r;
  logic [flpc_pkg::QUO_W-1:0] low_r, low_nxt;
  logic [flpc_pkg::QUO_W-1:0] q_r, q_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic                       run_r, run_nxt;
  logic                       done_r, done_nxt;
  logic [flpc_pkg::DEN_W:0]   trial;
  logic [flpc_pkg::DEN_W:0]   diff;

  assign trial = {rem_r, low_r[flpc_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num[flpc_pkg::NUM_W-1:flpc_pkg::QUO_W];
      low_nxt = num[flpc_pkg::QUO_W-1:0];
      q_nxt   = '0;
      cnt_nxt = 4'(flpc_pkg::QUO_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[flpc_pkg::DEN_W-1:0];
        q_nxt   = {q_r[flpc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[flpc_pkg::DEN_W-1:0];
        q_nxt   = {q_r[flpc_pkg::QUO_W-2:0], 1'b0};
      end
      low_nxt = {low_r[flpc_pkg::QUO_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ----- rtl/core/flpc_dp.sv -----
// datapath: timestamp store, playback state, frame walk and fade opacity
// depends on flpc_pkg and flpc_div
module flpc_dp #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  flpc_pkg::flpc_cmd_t   cmd,
  output flpc_pkg::flpc_stat_t  stat,
  input  logic [2:0]            in_cmd,
  input  logic [31:0]           in_time_value,
  input  logic                  in_from_start,
  input  logic [15:0]           frame_period,
  input  logic                  loop_enable,
  input  logic                  fade_in_enable,
  input  logic [15:0]           fade_in_ticks,
  input  logic                  fade_out_enable,
  input  logic [15:0]           fade_out_ticks,
  input  logic [7:0]            base_alpha,
  output logic [2:0]            status,
  output logic [9:0]            frame_index,
  output logic                  frame_shown,
  output logic                  new_frame,
  output logic [7:0]            opacity,
  output logic                  is_playing,
  output logic                  is_paused,
  output logic                  is_done,
  output logic [31:0]           total_duration,
  output logic [31:0]           play_position
);
  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);

  logic [31:0]   mem [MAX_FRAMES];
  logic [31:0]   rd_r;

  logic [2:0]    cmd_r;
  logic [31:0]   tv_r;
  logic          fs_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] shown_r, shown_nxt;
  logic [CW-1:0] next_r, next_nxt;
  logic          valid_r, valid_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [31:0]   dur_r, dur_nxt;
  logic [3:0]    flags_r, flags_nxt;
  logic [31:0]   first_r, first_nxt;
  logic [31:0]   last_r, last_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          fresh_r, fresh_nxt;
  logic          walk_r, walk_nxt;
  logic [7:0]    opac_r, opac_nxt;
  logic          wr_en;

  logic [31:0]   pos_tick;
  logic [31:0]   rec_gap;
  logic [31:0]   rec_first;
  logic [32:0]   rec_dur;
  logic [32:0]   fo_sum;
  logic [31:0]   fo_left;
  logic [flpc_pkg::NUM_W-1:0] div_num;
  logic [flpc_pkg::DEN_W-1:0] div_den;
  logic          div_done;
  logic [flpc_pkg::QUO_W-1:0] div_q;

  // tick position after the optional advance
  always_comb begin
    pos_tick = pos_r;
    if (!flags_r[flpc_pkg::FL_FIRST] && !flags_r[flpc_pkg::FL_PAUSED] &&
        pos_r != 32'hFFFF_FFFF)
      pos_tick = pos_r + 32'd1;
  end

  assign rec_gap   = tv_r - last_r;
  assign rec_first = (count_r == '0) ? tv_r : first_r;
  assign rec_dur   = {1'b0, tv_r - rec_first} + {17'd0, frame_period};
  assign fo_sum    = {1'b0, pos_r} + {17'd0, fade_out_ticks};
  assign fo_left   = (pos_r < dur_r) ? (dur_r - pos_r) : 32'd0;

  always_comb begin
    count_nxt  = count_r;
    shown_nxt  = shown_r;
    next_nxt   = next_r;
    valid_nxt  = valid_r;
    pos_nxt    = pos_r;
    dur_nxt    = dur_r;
    flags_nxt  = flags_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    fresh_nxt  = fresh_r;
    walk_nxt   = walk_r;
    opac_nxt   = opac_r;
    wr_en      = 1'b0;
    if (cmd.exec) begin
      status_nxt = flpc_pkg::ST_OK;
      fresh_nxt  = 1'b0;
      walk_nxt   = 1'b0;
      case (cmd_r)
        flpc_pkg::CMD_RECORD: begin
          if (flags_r[flpc_pkg::FL_PLAYING]) begin
            status_nxt = flpc_pkg::ST_PLAYING;
          end else if (count_r != '0 && last_r > tv_r) begin
            status_nxt = flpc_pkg::ST_OUT_ORDER;
          end else if (count_r != '0 && rec_gap < {16'd0, frame_period}) begin
            status_nxt = flpc_pkg::ST_TOO_SOON;
          end else if (count_r >= MAX_CNT) begin
            status_nxt = flpc_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            first_nxt = rec_first;
            last_nxt  = tv_r;
            dur_nxt   = rec_dur[32] ? 32'hFFFF_FFFF : rec_dur[31:0];
          end
        end
        flpc_pkg::CMD_TICK: begin
          if (flags_r[flpc_pkg::FL_PLAYING]) begin
            if (flags_r[flpc_pkg::FL_FIRST]) begin
              flags_nxt[flpc_pkg::FL_FIRST] = 1'b0;
              fresh_nxt = 1'b1;
            end
            pos_nxt = pos_tick;
            if (pos_tick < dur_r) begin
              walk_nxt = 1'b1;
            end else if (loop_enable) begin
              shown_nxt = '0;
              valid_nxt = 1'b1;
              next_nxt  = CW'(1);
              pos_nxt   = '0;
              fresh_nxt = 1'b1;
            end else begin
              valid_nxt = 1'b0;
              flags_nxt = 4'b0100;
              fresh_nxt = 1'b0;
            end
          end
        end
        flpc_pkg::CMD_PLAY: begin
          if (count_r != '0) begin
            if (flags_r[flpc_pkg::FL_PAUSED] && !fs_r) begin
              flags_nxt[flpc_pkg::FL_PAUSED] = 1'b0;
            end else begin
              if (fs_r) pos_nxt = '0;
              shown_nxt = '0;
              valid_nxt = 1'b1;
              next_nxt  = CW'(1);
              flags_nxt = 4'b1001;
            end
          end
        end
        flpc_pkg::CMD_PAUSE: begin
          if (flags_r[flpc_pkg::FL_PLAYING]) flags_nxt[flpc_pkg::FL_PAUSED] = 1'b1;
        end
        flpc_pkg::CMD_RESUME: begin
          if (flags_r[flpc_pkg::FL_PLAYING]) flags_nxt[flpc_pkg::FL_PAUSED] = 1'b0;
        end
        flpc_pkg::CMD_STOP: begin
          flags_nxt = '0;
          pos_nxt   = '0;
          valid_nxt = 1'b0;
        end
        flpc_pkg::CMD_SEEK: begin
          pos_nxt = (tv_r > dur_r) ? dur_r : tv_r;
          if (flags_r[flpc_pkg::FL_PLAYING]) begin
            flags_nxt[flpc_pkg::FL_FIRST] = 1'b1;
            shown_nxt = '0;
            valid_nxt = 1'b1;
            next_nxt  = CW'(1);
          end
        end
        flpc_pkg::CMD_CLEAR: begin
          if (flags_r[flpc_pkg::FL_PLAYING]) begin
            flags_nxt = '0;
            pos_nxt   = '0;
            valid_nxt = 1'b0;
          end
          count_nxt = '0;
          dur_nxt   = '0;
        end
        default: begin
          status_nxt = flpc_pkg::ST_OK;
        end
      endcase
    end
    if (cmd.walk_step) begin
      shown_nxt = next_r[IW-1:0];
      next_nxt  = next_r + CW'(1);
      fresh_nxt = 1'b1;
    end
    if (cmd.fade_init) begin
      opac_nxt = (flags_r[flpc_pkg::FL_PLAYING] && valid_r) ? base_alpha : 8'd0;
    end
    if (div_done && div_q < opac_r) opac_nxt = div_q;
  end

  // divider operands: product registered inside the divider
  always_comb begin
    if (cmd.div_out) begin
      div_num = {16'd0, base_alpha} * {8'd0, fo_left[15:0]};
      div_den = fade_out_ticks;
    end else begin
      div_num = {16'd0, base_alpha} * {8'd0, pos_r[15:0]};
      div_den = fade_in_ticks;
    end
  end

  flpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_in | cmd.div_out),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[IW-1:0]] <= tv_r;
    rd_r <= mem[next_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      shown_r <= '0;
      next_r  <= '0;
      valid_r <= 1'b0;
      pos_r   <= '0;
      dur_r   <= '0;
      flags_r <= '0;
      fresh_r <= 1'b0;
      walk_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      shown_r <= shown_nxt;
      next_r  <= next_nxt;
      valid_r <= valid_nxt;
      pos_r   <= pos_nxt;
      dur_r   <= dur_nxt;
      flags_r <= flags_nxt;
      fresh_r <= fresh_nxt;
      walk_r  <= walk_nxt;
    end
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    opac_r   <= opac_nxt;
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      tv_r  <= in_time_value;
      fs_r  <= in_from_start;
    end
  end

  assign stat.walk      = walk_r;
  assign stat.walk_more = (next_r < count_r) && (rd_r <= pos_r);
  assign stat.need_in   = flags_r[flpc_pkg::FL_PLAYING] && valid_r && fade_in_enable &&
                          (pos_r < {16'd0, fade_in_ticks});
  assign stat.need_out  = flags_r[flpc_pkg::FL_PLAYING] && valid_r && fade_out_enable &&
                          (fo_sum > {1'b0, dur_r});
  assign stat.div_done  = div_done;

  assign status         = status_r;
  assign frame_index    = valid_r ? 10'(shown_r) : 10'd0;
  assign frame_shown    = valid_r;
  assign new_frame      = fresh_r && valid_r;
  assign opacity        = opac_r;
  assign is_playing     = flags_r[flpc_pkg::FL_PLAYING];
  assign is_paused      = flags_r[flpc_pkg::FL_PAUSED];
  assign is_done        = flags_r[flpc_pkg::FL_DONE];
  assign total_duration = dur_r;
  assign play_position  = pos_r;
endmodule

// ----- rtl/core/flpc_ctrl.sv -----
// control state machine: sequences execute, frame walk, fade divides, result
// depends on flpc_pkg
module flpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output flpc_pkg::flpc_cmd_t  cmd,
  input  flpc_pkg::flpc_stat_t stat
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_WRD  = 4'd2;
  localparam logic [3:0] S_WCMP = 4'd3;
  localparam logic [3:0] S_FI   = 4'd4;
  localparam logic [3:0] S_FIW  = 4'd5;
  localparam logic [3:0] S_FO   = 4'd6;
  localparam logic [3:0] S_FOW  = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_WRD;
      end
      S_WRD: begin
        state_nxt = stat.walk ? S_WCMP : S_FI;
      end
      S_WCMP: begin
        if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_WRD;
        end else begin
          state_nxt = S_FI;
        end
      end
      S_FI: begin
        cmd.fade_init = 1'b1;
        if (stat.need_in) begin
          cmd.div_in = 1'b1;
          state_nxt  = S_FIW;
        end else begin
          state_nxt = S_FO;
        end
      end
      S_FIW: begin
        if (stat.div_done) state_nxt = S_FO;
      end
      S_FO: begin
        if (stat.need_out) begin
          cmd.div_out = 1'b1;
          state_nxt   = S_FOW;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_FOW: begin
        if (stat.div_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ----- rtl/core/frame_loop_playback_controller.sv -----
// frame loop playback controller: top level with register port and assertions
// depends on flpc_pkg, flpc_ctrl, flpc_dp and the defines header
//
// usage:
//  - commands enter on start/in_* ports; a transfer happens when start is high
//    and busy is low. fields are captured at that edge
//  - each command yields one result, shown on out_* for exactly one cycle with
//    out_valid high; the receiver cannot stall, so it must take it then
//  - busy stays high from the transfer until the result cycle ends, so one
//    command is in flight at a time
//  - a command with no fade divide and no frame walk passes the execute, walk read,
//    fade-in, fade-out and result states; a tick that stays inside the timeline
//    adds a compare state, plus a store read and a compare for each stored frame
//    it passes; each active fade ramp adds a pass of the shared 8-step divider
//  - a new command can transfer once busy drops, the cycle after the result
//  - registers are written over the apb port only while idle; pready is tied
//    high; the user is bound to that idle rule, the block does not enforce it
//  - reset (rst_n low, synchronous) empties the store, stops playback and
//    loads the register defaults; the timestamp store itself is not cleared
`include "frame_loop_playback_controller_defines.svh"
module frame_loop_playback_controller #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_time_value,
  input  logic        in_from_start,
  // result channel
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_frame_index,
  output logic        out_frame_shown,
  output logic        out_new_frame,
  output logic [7:0]  out_opacity,
  output logic        out_is_playing,
  output logic        out_is_paused,
  output logic        out_is_done,
  output logic [31:0] out_total_duration,
  output logic [31:0] out_play_position,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] period_r;
  logic        loop_r;
  logic        fi_en_r;
  logic [15:0] fi_ticks_r;
  logic        fo_en_r;
  logic [15:0] fo_ticks_r;
  logic [7:0]  alpha_r;
  logic        wr_xfer;
  logic [2:0]  reg_idx;

  flpc_pkg::flpc_cmd_t  dp_cmd;
  flpc_pkg::flpc_stat_t dp_stat;

  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= 16'd33;
      loop_r     <= 1'b0;
      fi_en_r    <= 1'b0;
      fi_ticks_r <= 16'd0;
      fo_en_r    <= 1'b0;
      fo_ticks_r <= 16'd0;
      alpha_r    <= 8'd255;
    end else if (wr_xfer) begin
      case (reg_idx)
        flpc_pkg::REG_PERIOD:   period_r   <= pwdata[15:0];
        flpc_pkg::REG_LOOP:     loop_r     <= pwdata[0];
        flpc_pkg::REG_FI_EN:    fi_en_r    <= pwdata[0];
        flpc_pkg::REG_FI_TICKS: fi_ticks_r <= pwdata[15:0];
        flpc_pkg::REG_FO_EN:    fo_en_r    <= pwdata[0];
        flpc_pkg::REG_FO_TICKS: fo_ticks_r <= pwdata[15:0];
        flpc_pkg::REG_ALPHA:    alpha_r    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      flpc_pkg::REG_PERIOD:   prdata = {16'd0, period_r};
      flpc_pkg::REG_LOOP:     prdata = {31'd0, loop_r};
      flpc_pkg::REG_FI_EN:    prdata = {31'd0, fi_en_r};
      flpc_pkg::REG_FI_TICKS: prdata = {16'd0, fi_ticks_r};
      flpc_pkg::REG_FO_EN:    prdata = {31'd0, fo_en_r};
      flpc_pkg::REG_FO_TICKS: prdata = {16'd0, fo_ticks_r};
      flpc_pkg::REG_ALPHA:    prdata = {24'd0, alpha_r};
      default:                prdata = 32'd0;
    endcase
  end

  // sequencing
  flpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // store, playback state and opacity
  flpc_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .in_cmd          (in_cmd),
    .in_time_value   (in_time_value),
    .in_from_start   (in_from_start),
    .frame_period    (period_r),
    .loop_enable     (loop_r),
    .fade_in_enable  (fi_en_r),
    .fade_in_ticks   (fi_ticks_r),
    .fade_out_enable (fo_en_r),
    .fade_out_ticks  (fo_ticks_r),
    .base_alpha      (alpha_r),
    .status          (out_status),
    .frame_index     (out_frame_index),
    .frame_shown     (out_frame_shown),
    .new_frame       (out_new_frame),
    .opacity         (out_opacity),
    .is_playing      (out_is_playing),
    .is_paused       (out_is_paused),
    .is_done         (out_is_done),
    .total_duration  (out_total_duration),
    .play_position   (out_play_position)
  );

  // a result only comes while a command is in flight
  `FLPC_ASSERT_IMPL(a_result_in_flight, out_valid, busy, "result strobe while idle")
  // a transfer always starts work
  `FLPC_ASSERT_NEXT(a_xfer_busy, start && !busy, busy, "transfer did not start work")
  // paused implies playing
  `FLPC_ASSERT_IMPL(a_pause_play, out_valid && out_is_paused, out_is_playing,
                    "paused while stopped")
  // hidden frame shows index zero and no opacity
  `FLPC_ASSERT_IMPL(a_hidden_zero, out_valid && !out_frame_shown,
                    out_frame_index == 10'd0 && out_opacity == 8'd0, "hidden frame not zeroed")
endmodule

// ----- tb/flpc_checker.sv -----
// checker for the frame loop playback controller: mirrors the timeline state,
// predicts one result per command transfer and compares it; depends on flpc_pkg
`timescale 1ns / 100ps
module flpc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_time_value,
  input  logic        in_from_start,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [9:0]  out_frame_index,
  input  logic        out_frame_shown,
  input  logic        out_new_frame,
  input  logic [7:0]  out_opacity,
  input  logic        out_is_playing,
  input  logic        out_is_paused,
  input  logic        out_is_done,
  input  logic [31:0] out_total_duration,
  input  logic [31:0] out_play_position,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);

  localparam int FRAMES = 1024;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  index;
    logic        shown;
    logic        fresh;
    logic [7:0]  opacity;
    logic        playing;
    logic        paused;
    logic        done;
    logic [31:0] duration;
    logic [31:0] position;
  } playback_result_t;

  playback_result_t expected_results[$];

  // register mirror
  logic [15:0] period, fi_ticks, fo_ticks;
  logic        loop_en, fi_en, fo_en;
  logic [7:0]  alpha;

  // timeline mirror
  logic [31:0] stamps [FRAMES];
  logic [10:0] count, next_idx;
  logic [9:0]  shown_idx;
  logic        shown_v;
  logic [31:0] pos, dur;
  logic        playing, paused, done, first;

  assign pending = expected_results.size();

  function automatic void enqueue_result(input playback_result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void show_first();
    shown_idx = '0;
    shown_v   = 1'b1;
    next_idx  = 11'd1;
  endfunction

  function automatic void halt();
    {playing, paused, done, first} = '0;
    pos     = '0;
    shown_v = 1'b0;
  endfunction

  function automatic logic [7:0] opacity_now();
    longint unsigned a, best, v, left;
    a    = alpha;
    best = a;
    if (!playing || !shown_v) return 8'd0;
    if (fi_en && pos < fi_ticks) begin
      v = a * pos / fi_ticks;
      if (v < best) best = v;
    end
    // a zero-length fade-out ramp leaves the opacity alone
    if (fo_en && fo_ticks != 0 && (longint'(pos) + fo_ticks) > longint'(dur)) begin
      left = (pos < dur) ? dur - pos : 0;
      v = a * left / fo_ticks;
      if (v < best) best = v;
    end
    return best[7:0];
  endfunction

  function automatic logic [2:0] record_frame(input logic [31:0] t);
    logic [31:0] last;
    logic [10:0] li;
    longint unsigned span;
    if (playing) return flpc_pkg::ST_PLAYING;
    if (count > 0) begin
      li   = count - 11'd1;
      last = stamps[li[9:0]];
      if (last > t) return flpc_pkg::ST_OUT_ORDER;
      if (t - last < period) return flpc_pkg::ST_TOO_SOON;
    end
    if (count >= FRAMES) return flpc_pkg::ST_FULL;
    stamps[count[9:0]] = t;
    count++;
    span = longint'(t - stamps[0]) + period;
    dur  = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    return flpc_pkg::ST_OK;
  endfunction

  function automatic logic advance_tick();
    logic fresh;
    fresh = 1'b0;
    if (!playing) return 1'b0;
    if (first) begin
      first = 1'b0;
      fresh = 1'b1;
    end else if (!paused && pos != 32'hFFFF_FFFF) begin
      pos++;
    end
    if (pos < dur) begin
      // walk every stored frame that the position has reached
      while (next_idx < count && stamps[next_idx[9:0]] <= pos) begin
        shown_idx = next_idx[9:0];
        next_idx++;
        fresh = 1'b1;
      end
    end else if (loop_en) begin
      show_first();
      pos   = '0;
      fresh = 1'b1;
    end else begin
      shown_v = 1'b0;
      {playing, paused, first} = '0;
      done = 1'b1;
      return 1'b0;
    end
    return fresh && shown_v;
  endfunction

  function automatic playback_result_t predict_result(input logic [2:0] cmd,
                                                      input logic [31:0] tv,
                                                      input logic fs);
    playback_result_t r;
    logic [2:0] st;
    logic fresh;
    st    = flpc_pkg::ST_OK;
    fresh = 1'b0;
    case (cmd)
      flpc_pkg::CMD_RECORD: st = record_frame(tv);
      flpc_pkg::CMD_TICK:   fresh = advance_tick();
      flpc_pkg::CMD_PLAY: begin
        if (count != 0) begin
          if (paused && !fs) begin
            paused = 1'b0;
          end else begin
            if (fs) pos = '0;
            show_first();
            {playing, paused, done, first} = 4'b1001;
          end
        end
      end
      flpc_pkg::CMD_PAUSE:  if (playing) paused = 1'b1;
      flpc_pkg::CMD_RESUME: if (playing) paused = 1'b0;
      flpc_pkg::CMD_STOP:   halt();
      flpc_pkg::CMD_SEEK: begin
        pos = (tv > dur) ? dur : tv;
        if (playing) begin
          first = 1'b1;
          show_first();
        end
      end
      default: begin
        if (playing) halt();
        count = '0;
        dur   = '0;
      end
    endcase
    r.status   = st;
    r.index    = shown_v ? shown_idx : 10'd0;
    r.shown    = shown_v;
    r.fresh    = fresh;
    r.opacity  = opacity_now();
    r.playing  = playing;
    r.paused   = paused;
    r.done     = done;
    r.duration = dur;
    r.position = pos;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    playback_result_t e;
    if (!rst_n) begin
      period = 16'd33; loop_en = 0; fi_en = 0; fi_ticks = 0;
      fo_en = 0; fo_ticks = 0; alpha = 8'd255;
      count = 0; next_idx = 0; shown_idx = 0; shown_v = 0;
      pos = 0; dur = 0; {playing, paused, done, first} = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          flpc_pkg::REG_PERIOD:   period   = pwdata[15:0];
          flpc_pkg::REG_LOOP:     loop_en  = pwdata[0];
          flpc_pkg::REG_FI_EN:    fi_en    = pwdata[0];
          flpc_pkg::REG_FI_TICKS: fi_ticks = pwdata[15:0];
          flpc_pkg::REG_FO_EN:    fo_en    = pwdata[0];
          flpc_pkg::REG_FO_TICKS: fo_ticks = pwdata[15:0];
          flpc_pkg::REG_ALPHA:    alpha    = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result transfer", $time);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, out_status);
          check_field("frame_index", e.index, out_frame_index);
          check_field("frame_shown", e.shown, out_frame_shown);
          check_field("new_frame", e.fresh, out_new_frame);
          check_field("opacity", e.opacity, out_opacity);
          check_field("is_playing", e.playing, out_is_playing);
          check_field("is_paused", e.paused, out_is_paused);
          check_field("is_done", e.done, out_is_done);
          check_field("total_duration", e.duration, out_total_duration);
          check_field("play_position", e.position, out_play_position);
        end
      end
      if (start && !busy)
        enqueue_result(predict_result(in_cmd, in_time_value, in_from_start));
    end
  end

endmodule

// ----- tb/testbench.sv -----
// top of the frame loop playback controller testbench: clock, reset, command
// and register stimulus, verdict; depends on flpc_pkg, flpc_checker and the block
`timescale 1ns / 100ps
module testbench;

  // register index past the last one
  localparam logic [2:0] REG_NONE = 3'd7;

  logic        clk, rst_n;
  logic        start, busy;
  logic [2:0]  in_cmd;
  logic [31:0] in_time_value;
  logic        in_from_start;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [9:0]  out_frame_index;
  logic        out_frame_shown, out_new_frame;
  logic [7:0]  out_opacity;
  logic        out_is_playing, out_is_paused, out_is_done;
  logic [31:0] out_total_duration, out_play_position;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  int errors, pending;
  int idle_pct;     // chance in a hundred that the sender idles a cycle
  int sent;         // command transfers so far, drives the phase budget
  logic [15:0] cur_period;
  logic [31:0] first_stamp, last_stamp;

  frame_loop_playback_controller dut (.*);

  flpc_checker timeline_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // one command transfer; start stays high across back-to-back transfers
  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] tv, input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_time_value <= tv;
    in_from_start <= fs;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // let the block drain before touching the registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] per, input logic lp, input logic fi_en,
                               input logic [15:0] fi, input logic fo_en,
                               input logic [15:0] fo, input logic [7:0] alpha);
    drain();
    // upper bits mostly carry junk that the block must drop
    write_reg(flpc_pkg::REG_PERIOD,   {16'($urandom_range(65535)), per});
    write_reg(flpc_pkg::REG_LOOP,     {31'($urandom), lp});
    write_reg(flpc_pkg::REG_FI_EN,    {31'h7FFF_FFFF, fi_en});
    write_reg(flpc_pkg::REG_FI_TICKS, {16'hFFFF, fi});
    write_reg(flpc_pkg::REG_FO_EN,    {31'd0, fo_en});
    write_reg(flpc_pkg::REG_FO_TICKS, {16'h0000, fo});
    write_reg(flpc_pkg::REG_ALPHA,    {24'hFFFFFF, alpha});
    // index past the last register is ignored
    write_reg(REG_NONE, $urandom);
    cur_period = per;
    @(posedge clk);
  endtask

  function automatic logic [31:0] timeline_length();
    longint unsigned span;
    span = longint'(last_stamp - first_stamp) + cur_period;
    return (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
  endfunction

  // one session: clear, record a short well-formed timeline, then play it
  // with random transport commands and occasional noise
  task automatic run_session();
    int nrec, nops, r;
    logic [31:0] t, len;
    send_cmd(flpc_pkg::CMD_CLEAR, $urandom, rand_bit());
    nrec = $urandom_range(1, 10);
    first_stamp = $urandom_range(0, 3);
    last_stamp  = first_stamp;
    send_cmd(flpc_pkg::CMD_RECORD, first_stamp, rand_bit());
    for (int i = 1; i < nrec; i++) begin
      r = $urandom_range(99);
      if (r < 85) t = last_stamp + cur_period + $urandom_range(0, 4);
      else if (r < 92) t = last_stamp + $urandom_range(0, cur_period);
      else t = $urandom;
      send_cmd(flpc_pkg::CMD_RECORD, t, rand_bit());
      if (t >= last_stamp && t - last_stamp >= cur_period) last_stamp = t;
    end
    len = timeline_length();
    send_cmd(flpc_pkg::CMD_PLAY, $urandom, rand_bit());
    nops = $urandom_range(10, 60);
    for (int i = 0; i < nops; i++) begin
      r = $urandom_range(99);
      if (r < 62) send_cmd(flpc_pkg::CMD_TICK, $urandom, rand_bit());
      else if (r < 66) send_cmd(flpc_pkg::CMD_PAUSE, $urandom, rand_bit());
      else if (r < 70) send_cmd(flpc_pkg::CMD_RESUME, $urandom, rand_bit());
      else if (r < 74) send_cmd(flpc_pkg::CMD_PLAY, $urandom, rand_bit());
      else if (r < 80) begin
        // half the seeks land near the end so long timelines still finish
        t = rand_bit() ? len - $urandom_range(0, 6) : $urandom;
        send_cmd(flpc_pkg::CMD_SEEK, t, rand_bit());
      end else if (r < 82) send_cmd(flpc_pkg::CMD_STOP, $urandom, rand_bit());
      else if (r < 85) send_cmd(flpc_pkg::CMD_RECORD, $urandom, rand_bit());
      else if (r < 86) send_cmd(flpc_pkg::CMD_CLEAR, $urandom, rand_bit());
      else send_cmd(3'($urandom_range(7)), $urandom, rand_bit());
    end
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_cmd = flpc_pkg::CMD_TICK; in_time_value = '0;
    in_from_start = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0; sent = 0; cur_period = 16'd33;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass on reset settings (period 33)
    send_cmd(flpc_pkg::CMD_PLAY, 32'd0, 1'b0);            // empty store, ignored
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);            // not playing, ignored
    send_cmd(flpc_pkg::CMD_PAUSE, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_RESUME, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_RECORD, 32'd2, 1'b0);
    send_cmd(flpc_pkg::CMD_RECORD, 32'd10, 1'b0);         // too soon
    send_cmd(flpc_pkg::CMD_RECORD, 32'd1, 1'b0);          // out of order
    send_cmd(flpc_pkg::CMD_RECORD, 32'd40, 1'b0);
    send_cmd(flpc_pkg::CMD_PLAY, 32'd0, 1'b1);
    send_cmd(flpc_pkg::CMD_RECORD, 32'd100, 1'b0);        // refused while playing
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);            // first tick holds position
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_PAUSE, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_PLAY, 32'd0, 1'b0);            // acts as resume
    send_cmd(flpc_pkg::CMD_SEEK, 32'd39, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);            // reaches the second frame
    send_cmd(flpc_pkg::CMD_SEEK, 32'hFFFF_FFFF, 1'b0);    // clamped to duration
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);            // after the end without loop, ignored
    send_cmd(flpc_pkg::CMD_STOP, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_RECORD, 32'hFFFF_FFFF, 1'b0);  // duration saturates
    send_cmd(flpc_pkg::CMD_PLAY, 32'd0, 1'b1);
    send_cmd(flpc_pkg::CMD_SEEK, 32'hFFFF_FFFF, 1'b0);    // position at all ones
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_CLEAR, 32'd0, 1'b0);

    // zero period: equal stamps accepted, then fill the store past its end
    load_settings(16'd0, 1'b1, 1'b1, 16'd5, 1'b1, 16'd5, 8'd128);
    for (int i = 0; i < 1030; i++) send_cmd(flpc_pkg::CMD_RECORD, 32'(i / 2), 1'b0);
    send_cmd(flpc_pkg::CMD_RECORD, 32'd3, 1'b0);          // out of order beats full
    send_cmd(flpc_pkg::CMD_PLAY, 32'd0, 1'b1);
    send_cmd(flpc_pkg::CMD_SEEK, 32'd600, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);
    send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);            // walks the frames stamped up to position one
    for (int i = 0; i < 12; i++) send_cmd(flpc_pkg::CMD_TICK, 32'd0, 1'b0);

    // three idle profiles, each over extreme and typical settings
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 4; k++) begin
        idle_pct = 0;
        case (k)
          0: load_settings(16'hFFFF, 1'($urandom), 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF);
          1: load_settings(16'd1, 1'($urandom), 1'b1, 16'd0, 1'b1, 16'd0, 8'd0);
          default: load_settings(16'($urandom_range(1, 8)), 1'($urandom),
                                 1'($urandom), 16'($urandom_range(0, 40)),
                                 1'($urandom), 16'($urandom_range(0, 40)),
                                 8'($urandom));
        endcase
        idle_pct = (p == 0) ? 24 : (p == 1) ? 50 : 0;
        sent = 0;
        while (sent < 30) run_session();
      end
    end

    // final drain with a bound
    start <= 1'b0;
    idle_pct = 0;
    for (int w = 0; w < 20000 && (pending != 0 || busy); w++) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
